>>> rtl/pcpp_pkg.sv
// ----------------------------------------------------------------------------
// pcpp_pkg
// Types and constants shared by the profile centroid and peak picker.
// ----------------------------------------------------------------------------
package pcpp_pkg;

    localparam logic [1:0] MODE_CENTROID = 2'd0;
    localparam logic [1:0] MODE_PEAK     = 2'd1;
    localparam logic [1:0] MODE_VALLEY   = 2'd2;

    // 100 in Q16.16
    localparam int unsigned SCALE_BITS = 23;
    localparam logic [SCALE_BITS-1:0] SCALE_Q16_100 = 23'd6553600;

    localparam int unsigned MUL_STEPS = 24;
    localparam int unsigned DIV_STEPS = 40;

    typedef struct packed {
        logic [39:0] sample_mass;
        logic [23:0] sample_abundance;
        logic        last_sample;
    } t_sample;

    typedef struct packed {
        logic [39:0] point_mass;
        logic [31:0] point_value;
        logic        last_point;
        logic        point_error;
    } t_point;

    typedef struct packed {
        logic [39:0] mass;
        logic [63:0] area;
    } t_centroid;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SCALE
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

>>> rtl/pcpp_serial_unit.sv
// ----------------------------------------------------------------------------
// pcpp_serial_unit
// Shared bit-serial unit: shift-add multiply, restoring divide with 40-bit
// saturation, and area normalization by a stepped remainder recurrence.
// ----------------------------------------------------------------------------
module pcpp_serial_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pcpp_pkg::t_unit_ctl  i_ctl,
    input  logic [63:0]          i_opa,
    input  logic [63:0]          i_opb,
    output pcpp_pkg::t_unit_sts  o_sts,
    output logic [63:0]          o_result
);

    pcpp_pkg::t_unit_op r_op;
    logic        r_busy;
    logic        r_done;
    logic [63:0] r_acc;
    logic [63:0] r_opa;
    logic [63:0] r_opb;
    logic [63:0] r_dlt;
    logic [pcpp_pkg::SCALE_BITS-1:0] r_q;
    logic [5:0]  r_cnt;
    logic        r_phase;

    logic [63:0] mul_sum;
    logic [41:0] div_trial;
    logic        div_ge;
    logic [65:0] sc_dbl;
    logic        sc_dbl_ge;
    logic [64:0] sc_sub;
    logic        sc_sub_ge;

    assign mul_sum   = r_acc + (r_opb[0] ? r_opa : 64'd0);
    assign div_trial = {1'b0, r_acc[39:0], r_opa[39]} - {2'b00, r_opb[39:0]};
    assign div_ge    = ~div_trial[41];
    assign sc_dbl    = {1'b0, r_acc, 1'b0} - {2'b00, r_opb};
    assign sc_dbl_ge = ~sc_dbl[65];
    assign sc_sub    = {1'b0, r_acc} - {1'b0, r_dlt};
    assign sc_sub_ge = ~sc_sub[64];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= pcpp_pkg::OP_MUL;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_op    <= i_ctl.op;
                r_phase <= 1'b0;
                unique case (i_ctl.op)
                    pcpp_pkg::OP_MUL: begin
                        r_acc  <= '0;
                        r_opa  <= i_opa;
                        r_opb  <= i_opb;
                        r_cnt  <= 6'(pcpp_pkg::MUL_STEPS - 1);
                        r_busy <= 1'b1;
                    end
                    pcpp_pkg::OP_DIV: begin
                        // quotient at or above 2^40 saturates
                        if ({40'd0, i_opa[63:40]} >= i_opb) begin
                            r_opa  <= {24'd0, {40{1'b1}}};
                            r_done <= 1'b1;
                        end else begin
                            r_acc  <= {40'd0, i_opa[63:40]};
                            r_opa  <= {24'd0, i_opa[39:0]};
                            r_opb  <= i_opb;
                            r_cnt  <= 6'(pcpp_pkg::DIV_STEPS - 1);
                            r_busy <= 1'b1;
                        end
                    end
                    pcpp_pkg::OP_SCALE: begin
                        if (i_opa >= i_opb) begin
                            r_q    <= pcpp_pkg::SCALE_Q16_100;
                            r_done <= 1'b1;
                        end else begin
                            r_acc  <= '0;
                            r_q    <= '0;
                            r_opa  <= i_opa;
                            r_opb  <= i_opb;
                            r_dlt  <= i_opb - i_opa;
                            r_cnt  <= 6'(pcpp_pkg::SCALE_BITS - 1);
                            r_busy <= 1'b1;
                        end
                    end
                    default: begin
                        r_done <= 1'b1;
                    end
                endcase
            end else if (r_busy) begin
                unique case (r_op)
                    pcpp_pkg::OP_MUL: begin
                        r_acc <= mul_sum;
                        r_opa <= {r_opa[62:0], 1'b0};
                        r_opb <= {1'b0, r_opb[63:1]};
                        if (r_cnt == 6'd0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt - 6'd1;
                        end
                    end
                    pcpp_pkg::OP_DIV: begin
                        r_acc <= {24'd0,
                                  div_ge ? div_trial[39:0] : {r_acc[38:0], r_opa[39]}};
                        r_opa <= {r_opa[62:0], div_ge};
                        if (r_cnt == 6'd0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt - 6'd1;
                        end
                    end
                    pcpp_pkg::OP_SCALE: begin
                        if (!r_phase) begin
                            // remainder doubling
                            r_acc <= sc_dbl_ge ? sc_dbl[63:0] : {r_acc[62:0], 1'b0};
                            r_q   <= {r_q[pcpp_pkg::SCALE_BITS-2:0], 1'b0}
                                   + pcpp_pkg::SCALE_BITS'(sc_dbl_ge);
                            if (pcpp_pkg::SCALE_Q16_100[r_cnt[4:0]]) begin
                                r_phase <= 1'b1;
                            end else if (r_cnt == 6'd0) begin
                                r_busy <= 1'b0;
                                r_done <= 1'b1;
                            end else begin
                                r_cnt <= r_cnt - 6'd1;
                            end
                        end else begin
                            // add the area for a set bit of the scale
                            r_acc   <= sc_sub_ge ? sc_sub[63:0] : r_acc + r_opa;
                            r_q     <= r_q + pcpp_pkg::SCALE_BITS'(sc_sub_ge);
                            r_phase <= 1'b0;
                            if (r_cnt == 6'd0) begin
                                r_busy <= 1'b0;
                                r_done <= 1'b1;
                            end else begin
                                r_cnt <= r_cnt - 6'd1;
                            end
                        end
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        unique case (r_op)
            pcpp_pkg::OP_MUL:   o_result = r_acc;
            pcpp_pkg::OP_DIV:   o_result = {24'd0, r_opa[39:0]};
            pcpp_pkg::OP_SCALE: o_result = {41'd0, r_q};
            default:            o_result = '0;
        endcase
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

>>> rtl/pcpp_store.sv
// ----------------------------------------------------------------------------
// pcpp_store
// Centroid buffer: one write port and one registered read port.
// ----------------------------------------------------------------------------
module pcpp_store #(
    parameter int DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  pcpp_pkg::t_centroid           i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(DEPTH)-1:0]      i_raddr,
    output pcpp_pkg::t_centroid           o_rdata
);

    pcpp_pkg::t_centroid r_mem [DEPTH];
    pcpp_pkg::t_centroid r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/profile_centroid_peak_picker.sv
// modes 0, 2 and 3 run three shift-add multiplies per center, and mode 0 also
// a division when a segment closes; the last item in mode 0 adds the
// normalizing recurrence per stored segment. one item at a time; modes 0, 2
// and 3 go through the shared serial unit. reset is synchronous active low and
// clears control state; the centroid buffer is not cleared and needs no
// clearing pass
// ----------------------------------------------------------------------------
// profile_centroid_peak_picker
// Three-sample window peak, valley and centroid picker over mass profiles.
// ----------------------------------------------------------------------------
module profile_centroid_peak_picker #(
    parameter int CENTROID_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pcpp_pkg::t_sample   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pcpp_pkg::t_point    o_out_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_wdata
);

    localparam int AW = $clog2(CENTROID_DEPTH);
    localparam int CW = $clog2(CENTROID_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_MULGO, S_MUL, S_TEST, S_AREA, S_CLOSE, S_DIV,
        S_SHIFT, S_PEAK, S_DRD, S_DWAIT, S_DSCALE, S_DEMIT
    } t_state;

    t_state      r_state;
    logic [1:0]  r_mode;
    logic [39:0] r_nm, r_om, r_cm;
    logic [23:0] r_na, r_oa, r_ca;
    logic        r_last;
    logic [1:0]  r_seen;
    logic [63:0] r_wsum, r_usum, r_lsum, r_largest, r_area;
    logic [39:0] r_asum;
    logic [39:0] r_step;
    logic [1:0]  r_msel;
    logic [CW-1:0] r_count;
    logic        r_ovf;
    logic [AW-1:0] r_k;
    logic [31:0] r_val;
    logic        r_out_valid;
    pcpp_pkg::t_point r_out;

    pcpp_pkg::t_unit_ctl unit_ctl;
    pcpp_pkg::t_unit_sts unit_sts;
    logic [63:0] unit_a, unit_b, unit_res;
    pcpp_pkg::t_centroid st_wdata, st_rdata;
    logic        st_we;

    logic        out_free;
    logic        peak_hit, close_hit, div_go, has_room, dump_last, clr_prof;
    logic [40:0] asum_add;
    logic [64:0] sat_sum;
    logic [63:0] sat_base;

    assign out_free  = ~r_out_valid | i_out_ready;
    assign peak_hit  = (r_ca > r_na) && (r_ca > r_oa) && (r_om < r_cm) && (r_cm < r_nm);
    assign close_hit = ((r_ca <= r_na) && (r_ca < r_oa)) || r_last;
    assign has_room  = r_count < CW'(CENTROID_DEPTH);
    assign div_go    = (r_mode == pcpp_pkg::MODE_CENTROID) && (r_asum != 40'd0) && has_room;
    assign dump_last = (CW'(r_k) + CW'(1)) == r_count;
    assign asum_add  = {1'b0, r_asum} + {17'd0, r_ca};

    always_comb begin
        unique case (r_msel)
            2'd0:    sat_base = r_wsum;
            2'd1:    sat_base = r_usum;
            default: sat_base = r_lsum;
        endcase
    end
    assign sat_sum = {1'b0, sat_base} + {1'b0, unit_res};

    // shared unit control
    always_comb begin
        unit_ctl.start = 1'b0;
        unit_ctl.op    = pcpp_pkg::OP_MUL;
        unit_a         = '0;
        unit_b         = '0;
        unique case (r_state)
            S_MULGO: begin
                unit_ctl.start = 1'b1;
                unique case (r_msel)
                    2'd0: begin
                        unit_a = {24'd0, r_cm};
                        unit_b = {40'd0, r_ca};
                    end
                    2'd1: begin
                        unit_a = {24'd0, r_step};
                        unit_b = {40'd0, r_ca};
                    end
                    default: begin
                        unit_a = {24'd0, r_step};
                        unit_b = {40'd0, r_oa};
                    end
                endcase
            end
            S_CLOSE: begin
                unit_ctl.start = div_go && ((r_mode != pcpp_pkg::MODE_VALLEY) || out_free);
                unit_ctl.op    = pcpp_pkg::OP_DIV;
                unit_a         = r_wsum;
                unit_b         = {24'd0, r_asum};
            end
            S_DWAIT: begin
                unit_ctl.start = (r_largest != 64'd0);
                unit_ctl.op    = pcpp_pkg::OP_SCALE;
                unit_a         = st_rdata.area;
                unit_b         = r_largest;
            end
            default: begin
                unit_ctl.start = 1'b0;
            end
        endcase
    end

    pcpp_serial_unit u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (unit_ctl),
        .i_opa    (unit_a),
        .i_opb    (unit_b),
        .o_sts    (unit_sts),
        .o_result (unit_res)
    );

    assign st_we         = (r_state == S_DIV) && unit_sts.done;
    assign st_wdata.mass = unit_res[39:0];
    assign st_wdata.area = r_area;

    pcpp_store #(.DEPTH(CENTROID_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (st_wdata),
        .i_re    (r_state == S_DRD),
        .i_raddr (r_k),
        .o_rdata (st_rdata)
    );

    assign clr_prof = ((r_state == S_SHIFT) && r_last
                       && !((r_mode == pcpp_pkg::MODE_CENTROID) && (r_count != '0)))
                   || ((r_state == S_DEMIT) && out_free && dump_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= pcpp_pkg::MODE_CENTROID;
            r_om        <= '0;
            r_oa        <= '0;
            r_cm        <= '0;
            r_ca        <= '0;
            r_seen      <= '0;
            r_wsum      <= '0;
            r_asum      <= '0;
            r_usum      <= '0;
            r_lsum      <= '0;
            r_largest   <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_msel      <= '0;
            r_k         <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_nm   <= i_in_item.sample_mass;
                        r_na   <= i_in_item.sample_abundance;
                        r_last <= i_in_item.last_sample;
                        if (r_seen != 2'd2) begin
                            r_state <= S_SHIFT;
                        end else if (r_mode == pcpp_pkg::MODE_PEAK) begin
                            r_state <= S_PEAK;
                        end else begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PEAK: begin
                    if (!peak_hit) begin
                        r_state <= S_SHIFT;
                    end else if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out <= '{point_mass: r_cm, point_value: {8'd0, r_ca},
                                   last_point: r_last, point_error: 1'b0};
                        r_state <= S_SHIFT;
                    end
                end
                S_PREP: begin
                    r_asum  <= asum_add[40] ? {40{1'b1}} : asum_add[39:0];
                    // a mass step that goes backward counts as zero
                    r_step  <= (r_cm >= r_om) ? r_cm - r_om : 40'd0;
                    r_msel  <= 2'd0;
                    r_state <= S_MULGO;
                end
                S_MULGO: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (unit_sts.done) begin
                        unique case (r_msel)
                            2'd0:    r_wsum <= sat_sum[64] ? {64{1'b1}} : sat_sum[63:0];
                            2'd1:    r_usum <= sat_sum[64] ? {64{1'b1}} : sat_sum[63:0];
                            default: r_lsum <= sat_sum[64] ? {64{1'b1}} : sat_sum[63:0];
                        endcase
                        if (r_msel == 2'd2) begin
                            r_state <= S_TEST;
                        end else begin
                            r_msel  <= r_msel + 2'd1;
                            r_state <= S_MULGO;
                        end
                    end
                end
                S_TEST: begin
                    r_state <= close_hit ? S_AREA : S_SHIFT;
                end
                S_AREA: begin
                    r_area  <= {1'b0, r_usum[63:1]} + {1'b0, r_lsum[63:1]}
                             + {63'd0, r_usum[0] & r_lsum[0]};
                    r_state <= S_CLOSE;
                end
                S_CLOSE: begin
                    if ((r_mode != pcpp_pkg::MODE_VALLEY) || out_free) begin
                        if (r_mode == pcpp_pkg::MODE_VALLEY) begin
                            r_out_valid <= 1'b1;
                            r_out <= '{point_mass: r_cm, point_value: {8'd0, r_ca},
                                       last_point: r_last, point_error: 1'b0};
                        end
                        if (r_area > r_largest) begin
                            r_largest <= r_area;
                        end
                        if ((r_mode == pcpp_pkg::MODE_CENTROID) && (r_asum != 40'd0)
                                && !has_room) begin
                            r_ovf <= 1'b1;
                        end
                        if (div_go) begin
                            r_state <= S_DIV;
                        end else begin
                            r_wsum  <= '0;
                            r_asum  <= '0;
                            r_usum  <= '0;
                            r_lsum  <= '0;
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_DIV: begin
                    if (unit_sts.done) begin
                        r_count <= r_count + CW'(1);
                        r_wsum  <= '0;
                        r_asum  <= '0;
                        r_usum  <= '0;
                        r_lsum  <= '0;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_om <= r_cm;
                    r_oa <= r_ca;
                    r_cm <= r_nm;
                    r_ca <= r_na;
                    if (r_seen != 2'd2) begin
                        r_seen <= r_seen + 2'd1;
                    end
                    if (r_last && (r_mode == pcpp_pkg::MODE_CENTROID) && (r_count != '0)) begin
                        r_k     <= '0;
                        r_state <= S_DRD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DRD: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (r_largest == 64'd0) begin
                        r_val   <= '0;
                        r_state <= S_DEMIT;
                    end else begin
                        r_state <= S_DSCALE;
                    end
                end
                S_DSCALE: begin
                    if (unit_sts.done) begin
                        r_val   <= unit_res[31:0];
                        r_state <= S_DEMIT;
                    end
                end
                S_DEMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out <= '{point_mass: st_rdata.mass, point_value: r_val,
                                   last_point: dump_last,
                                   point_error: r_ovf | (r_largest == 64'd0)};
                        if (dump_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + AW'(1);
                            r_state <= S_DRD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (clr_prof) begin
                r_om      <= '0;
                r_oa      <= '0;
                r_cm      <= '0;
                r_ca      <= '0;
                r_seen    <= '0;
                r_wsum    <= '0;
                r_asum    <= '0;
                r_usum    <= '0;
                r_lsum    <= '0;
                r_largest <= '0;
                r_count   <= '0;
                r_ovf     <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // checks

    a_idle_unit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !unit_sts.busy)
        else $error("serial unit busy while idle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CENTROID_DEPTH))
        else $error("centroid count beyond buffer depth");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unit_sts.done |-> (r_state == S_MUL || r_state == S_DIV || r_state == S_DSCALE))
        else $error("unit result arrived with no one waiting");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= 2'd2)
        else $error("window fill count out of range");

    a_dump_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEMIT) |-> (r_count != '0 && r_last))
        else $error("buffer dump without stored segments");

endmodule

>>> test/profile_centroid_peak_picker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// profile_centroid_peak_picker_tb
// Drives mass profiles in all modes with random gaps and stalls, predicts
// peaks, valleys and normalized centroids, and compares every result item.
// ----------------------------------------------------------------------------
module profile_centroid_peak_picker_tb;

    localparam int DEPTH = 64;
    localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX40 = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] HUNDRED_Q16 = 64'd6553600;
    localparam longint CYCLE_LIMIT = 64'd6_000_000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    pcpp_pkg::t_sample  in_item = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    pcpp_pkg::t_point   out_item;
    logic     cfg_we = 1'b0;
    logic [1:0] cfg_wdata = 2'd0;

    profile_centroid_peak_picker #(.CENTROID_DEPTH(DEPTH)) uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [1:0]  pm_mode;
    logic [39:0] w_om, w_cm;
    logic [23:0] w_oa, w_ca;
    int          w_seen;
    logic [63:0] s_wm, s_ab, s_up, s_lo, s_top;
    logic [39:0] st_mass [DEPTH];
    logic [63:0] st_area [DEPTH];
    int          st_count;
    bit          st_ovf;

    pcpp_pkg::t_sample pending_samples[$];
    pcpp_pkg::t_point  expected_points[$];
    int      mismatches = 0;
    int      points_seen = 0;
    int      samples_sent = 0;
    longint  cycles = 0;
    int      hold_cycles = 0;
    int      hold_len = 0;
    int      hold_req = 0;
    int      hold_ack = 0;
    int      in_wait = 0;
    int      out_wait = 0;

    function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? SAT64 : s[63:0];
    endfunction

    function automatic logic [31:0] norm_area(logic [63:0] area, logic [63:0] top);
        logic [127:0] p;
        if (area >= top) return HUNDRED_Q16[31:0];
        p = {64'd0, area} * {64'd0, HUNDRED_Q16};
        return 32'(p / {64'd0, top});
    endfunction

    task automatic clear_profile();
        w_om = '0; w_cm = '0; w_oa = '0; w_ca = '0; w_seen = 0;
        s_wm = '0; s_ab = '0; s_up = '0; s_lo = '0; s_top = '0;
        st_count = 0; st_ovf = 0;
    endtask

    task automatic predict_sample(pcpp_pkg::t_sample s);
        logic [63:0] step, area, mean;
        pcpp_pkg::t_point p;
        bit lst;
        lst = s.last_sample;
        if (w_seen >= 2) begin
            if (pm_mode == pcpp_pkg::MODE_PEAK) begin
                if (w_ca > s.sample_abundance && w_ca > w_oa && w_om < w_cm
                        && w_cm < s.sample_mass) begin
                    p = '{w_cm, 32'(w_ca), lst, 1'b0};
                    expected_points.push_back(p);
                end
            end else begin
                step = (w_cm >= w_om) ? 64'(w_cm - w_om) : 64'd0;
                s_wm = sadd(s_wm, 64'(w_ca) * 64'(w_cm));
                s_ab = s_ab + 64'(w_ca);
                if (s_ab > MAX40) s_ab = MAX40;
                s_up = sadd(s_up, step * 64'(w_ca));
                s_lo = sadd(s_lo, step * 64'(w_oa));
                if ((w_ca <= s.sample_abundance && w_ca < w_oa) || lst) begin
                    area = (s_up >> 1) + (s_lo >> 1) + 64'(s_up[0] & s_lo[0]);
                    if (pm_mode == pcpp_pkg::MODE_VALLEY) begin
                        p = '{w_cm, 32'(w_ca), lst, 1'b0};
                        expected_points.push_back(p);
                    end
                    if (area > s_top) s_top = area;
                    if (pm_mode == pcpp_pkg::MODE_CENTROID && s_ab != 0) begin
                        if (st_count < DEPTH) begin
                            mean = s_wm / s_ab;
                            if (mean > MAX40) mean = MAX40;
                            st_mass[st_count] = mean[39:0];
                            st_area[st_count] = area;
                            st_count++;
                        end else begin
                            st_ovf = 1;
                        end
                    end
                    s_wm = '0; s_ab = '0; s_up = '0; s_lo = '0;
                end
            end
        end
        w_om = w_cm; w_oa = w_ca;
        w_cm = s.sample_mass; w_ca = s.sample_abundance;
        if (w_seen < 2) w_seen++;
        if (lst) begin
            if (pm_mode == pcpp_pkg::MODE_CENTROID) begin
                for (int k = 0; k < st_count; k++) begin
                    p.point_mass = st_mass[k];
                    p.point_value = (s_top == 0) ? 32'd0 : norm_area(st_area[k], s_top);
                    p.last_point = (k + 1 == st_count);
                    p.point_error = st_ovf | (s_top == 0);
                    expected_points.push_back(p);
                end
            end
            clear_profile();
        end
    endtask

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                predict_sample(in_item);
                samples_sent++;
            end
            if (in_valid && !in_ready) begin
            end else if (in_wait > 0) begin
                in_valid <= 1'b0;
                in_wait <= in_wait - 1;
            end else if (pending_samples.size() > 0) begin
                in_item <= pending_samples.pop_front();
                in_valid <= 1'b1;
                in_wait <= $urandom_range(3) == 0 ? $urandom_range(17) : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk) begin
        if (hold_req != hold_ack) begin
            hold_cycles <= hold_len;
            hold_ack <= hold_req;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // monitor
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                points_seen++;
                if (expected_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item %p", out_item);
                end else if (out_item !== expected_points[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p",
                                 expected_points[0], out_item);
                    void'(expected_points.pop_front());
                end else begin
                    void'(expected_points.pop_front());
                end
            end
            if (hold_cycles > 0) begin
                out_ready <= 1'b0;
            end else if (out_wait > 0) begin
                out_ready <= 1'b0;
                out_wait <= out_wait - 1;
            end else begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    out_wait <= $urandom_range(3) == 0 ? $urandom_range(17) : 0;
            end
        end
    end

    always @(posedge clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic add_sample(logic [39:0] m, logic [23:0] a, bit lst);
        pcpp_pkg::t_sample s;
        s.sample_mass = m; s.sample_abundance = a; s.last_sample = lst;
        pending_samples.push_back(s);
    endtask

    // random profile: increasing mass with occasional repeats and drops
    task automatic add_profile(int n, bit wild);
        logic [39:0] m;
        logic [23:0] a;
        m = 40'({$urandom, $urandom});
        m = wild ? m : (m >> 2);
        for (int i = 0; i < n; i++) begin
            if (wild && $urandom_range(7) == 0) m = 40'({$urandom, $urandom});
            else m = m + 40'($urandom_range(3) == 0 ? 0 : $urandom_range(1 << 20));
            case ($urandom_range(3))
                0: a = 24'($urandom);
                1: a = 24'hFFFFFF - 24'($urandom_range(3));
                2: a = 24'($urandom_range(4));
                default: a = 24'($urandom_range(1000) + 1000 * (i % 3));
            endcase
            add_sample(m, a, i == n - 1);
        end
    endtask

    task automatic wait_idle();
        while (pending_samples.size() > 0 || in_valid || expected_points.size() > 0)
            @(posedge clk);
        repeat (200 * DEPTH) @(posedge clk);
    endtask

    task automatic set_mode(logic [1:0] m);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        pm_mode = m;
    endtask

    initial begin
        pm_mode = pcpp_pkg::MODE_CENTROID;
        clear_profile();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            set_mode(ph < 4 ? 2'(ph) : 2'($urandom_range(3)));
            // directed profiles: extremes, short profiles, flat and valleys
            if (ph < 4) begin
                add_sample(40'd0, 24'd0, 1);
                add_sample(40'd5, 24'd9, 0); add_sample(40'd6, 24'd1, 1);
                add_sample(40'd0, 24'd0, 0); add_sample(40'd0, 24'd0, 0);
                add_sample(40'd0, 24'd0, 1);
                add_sample(40'd10, 24'd1, 0); add_sample(40'd20, 24'hFFFFFF, 0);
                add_sample(40'd30, 24'd2, 0); add_sample(40'd40, 24'd7, 0);
                add_sample(40'd50, 24'd3, 1);
                add_sample(MAX40[39:0] - 40'd2, 24'hFFFFFF, 0);
                add_sample(MAX40[39:0] - 40'd1, 24'hFFFFFF, 0);
                add_sample(MAX40[39:0], 24'hFFFFFF, 0);
                add_sample(40'd100, 24'd5, 1);
            end
            if (ph == 4) begin
                // more valleys than the buffer holds
                for (int i = 0; i < 2 * DEPTH + 10; i++)
                    add_sample(40'(1000 + i), (i % 2) ? 24'd1 : 24'd500,
                               i == 2 * DEPTH + 9);
                hold_len = 3000;
                hold_req++;
            end
            for (int p = 0; p < 7; p++)
                add_profile($urandom_range(3, 8), $urandom_range(4) == 0);
            if (ph == 2) begin
                hold_len = 2000;
                hold_req++;
            end
            wait_idle();
        end
        $display("ran %0d samples over all modes, %0d result items checked",
                 samples_sent, points_seen);
        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
